@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker.
// Include guarded; holds macro definitions only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ design/jls_pkg.sv @@
// Package for the Jacobi solver: sizes, codes and shared types.
// No dependencies.
package jls_pkg;
  localparam int unsigned MaxSize = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned ValW = 32;
  localparam int unsigned AccW = 72;
  localparam int unsigned QuoW = 56;

  typedef enum logic [1:0] {
    KIND_MAT   = 2'd0,
    KIND_RHS   = 2'd1,
    KIND_GUESS = 2'd2,
    KIND_START = 2'd3
  } kind_e;

  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_TOL  = 2'd1;
  localparam logic [1:0] CFG_ITER = 2'd2;

  // divider handshake
  typedef struct packed {
    logic             go;
    logic [AccW-1:0]  num;
    logic [ValW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ValW-1:0]  quo;
  } div_rsp_t;
endpackage

@@ design/jls_div.sv @@
// Sequential signed divider, one quotient bit per cycle, saturating.
// Depends on jls_pkg.
module jls_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jls_pkg::div_req_t req_i,
  output jls_pkg::div_rsp_t rsp_o
);
  localparam int unsigned CntW = $clog2(jls_pkg::AccW + 1);

  logic [jls_pkg::AccW-1:0] num_q, num_d;
  logic [jls_pkg::ValW:0]   rem_q, rem_d;
  logic [jls_pkg::ValW-1:0] den_q, den_d;
  logic [jls_pkg::QuoW-1:0] quo_q, quo_d;
  logic                     ovf_q, ovf_d, neg_q, neg_d, run_q, run_d, done_q, done_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [jls_pkg::ValW:0]   trial;
  logic [jls_pkg::ValW-1:0] lim;
  logic [jls_pkg::QuoW-1:0] qmag;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q; ovf_d = ovf_q;
    neg_d = neg_q; run_d = run_q; cnt_d = cnt_q; done_d = 1'b0;
    trial = {rem_q[jls_pkg::ValW-1:0], num_q[jls_pkg::AccW-1]};
    if (req_i.go) begin
      neg_d = req_i.num[jls_pkg::AccW-1] ^ req_i.den[jls_pkg::ValW-1];
      num_d = req_i.num[jls_pkg::AccW-1] ? -req_i.num : req_i.num;
      den_d = req_i.den[jls_pkg::ValW-1] ? -req_i.den : req_i.den;
      rem_d = '0; quo_d = '0; ovf_d = 1'b0;
      cnt_d = CntW'(jls_pkg::AccW); run_d = 1'b1;
    end else if (run_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        if (cnt_q > CntW'(jls_pkg::QuoW)) ovf_d = 1'b1;
        quo_d = {quo_q[jls_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[jls_pkg::QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  // 32 fraction bits over 16 leaves a Q16.16 quotient as is
  assign qmag = quo_q;
  assign lim = {1'b0, {(jls_pkg::ValW-1){1'b1}}};
  always_comb begin
    if (ovf_q || (qmag > {{(jls_pkg::QuoW-jls_pkg::ValW){1'b0}}, lim})) begin
      rsp_o.quo = neg_q ? ~lim : lim;
    end else begin
      rsp_o.quo = neg_q ? -qmag[jls_pkg::ValW-1:0] : qmag[jls_pkg::ValW-1:0];
    end
    rsp_o.done = done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    quo_q <= quo_d; ovf_q <= ovf_d; neg_q <= neg_d;
  end
endmodule

@@ design/jacobi_linear_solver_unit.sv @@
// Top level of the Jacobi solver: stores, sequencer, shared MAC and divider.
// Depends on jls_pkg and jls_div.
//
//  port group   direction  handshake
//  load/start   in         start_i & !busy_o
//  config       in         cfg_we_i, no wait
//  result       out        res_valid_o, one cycle, no back-pressure
//
// A load is written straight into its store. A start first checks the diagonals, row by row.
// Each sweep row: the multiplier issues across the row, the pipe drains, then the divider
// produces the quotient bits and signals done.
// Results then leave one per cycle, registered from the sequencer's output state.
// Reset clears control and configuration; the stores hold data only.
// The receiver cannot stall.
module jacobi_linear_solver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  row_i,
  input  logic [3:0]  col_i,
  input  logic signed [31:0] value_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  output logic        res_valid_o,
  output logic [3:0]  index_o,
  output logic signed [31:0] solution_o,
  output logic        converged_o,
  output logic [15:0] sweeps_used_o,
  output logic        zero_pivot_o,
  output logic        last_o
);
  localparam int unsigned IW = jls_pkg::IdxW;
  localparam int unsigned VW = jls_pkg::ValW;
  localparam int unsigned AW = jls_pkg::AccW;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PIV   = 8'b00000010,
    S_MAC   = 8'b00000100,
    S_ADD   = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_CHK   = 8'b00100000,
    S_COPY  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  // stores
  logic [VW-1:0] coef_mem [jls_pkg::MaxSize*jls_pkg::MaxSize];
  logic [VW-1:0] rhs_q [jls_pkg::MaxSize];
  logic [VW-1:0] cur_q [jls_pkg::MaxSize];
  logic [VW-1:0] nxt_q [jls_pkg::MaxSize];
  logic [VW-1:0] coef_rd_q;

  logic [4:0]  size_q;
  logic [30:0] tol_q;
  logic [15:0] iter_q;

  logic [IW-1:0] i_q, i_d, j_q, j_d, n1;
  logic [15:0]   sw_q, sw_d;
  logic          zp_q, zp_d, conv_q, conv_d, diff_q, diff_d;
  // read pipe: coefficient valid (with its column), then product valid
  logic          rd_v_q, rd_v_d, prod_v_q, prod_v_d;
  logic [IW-1:0] rd_j_q, rd_j_d;
  logic [AW-1:0] acc_q, acc_d;
  logic signed [2*VW-1:0] prod_q;
  logic [VW-1:0] piv_q, piv_d;
  logic [IW-1:0] rd_row, rd_col;
  logic [15:0]   iters;
  logic [4:0]    nsz;

  jls_pkg::div_req_t dreq;
  jls_pkg::div_rsp_t drsp;

  jls_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign nsz = (size_q == 5'd0) ? 5'd1 : (size_q > 5'd16) ? 5'd16 : size_q;
  assign n1 = IW'(nsz - 5'd1);
  assign iters = (iter_q == 16'd0) ? 16'd1 : iter_q;
  assign busy_o = (state_q != S_IDLE);

  // |a-b| >= tolerance means not yet converged
  function automatic logic chg_ge_tol(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    logic [32:0] m;
    d = 33'($signed(a)) - 33'($signed(b));
    m = d[32] ? 33'(-d) : 33'(d);
    return m >= {2'b0, tol_q};
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 5'd16; tol_q <= 31'd66; iter_q <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jls_pkg::CFG_SIZE: size_q <= cfg_data_i[4:0];
        jls_pkg::CFG_TOL:  tol_q  <= cfg_data_i;
        jls_pkg::CFG_ITER: iter_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // coefficient memory: one write, one registered read
  always_comb begin
    rd_row = i_q;
    rd_col = (state_q == S_PIV) ? i_q : j_q;
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o && kind_i == jls_pkg::KIND_MAT) begin
      coef_mem[{row_i, col_i}] <= value_i;
    end
    coef_rd_q <= coef_mem[{rd_row, rd_col}];
  end

  // shared multiplier, registered; estimate is stable for the whole sweep
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(coef_rd_q) * $signed(cur_q[rd_j_q]);
  end

  always_comb begin
    state_d = state_q; i_d = i_q; j_d = j_q; sw_d = sw_q; zp_d = zp_q;
    conv_d = conv_q; diff_d = diff_q; acc_d = acc_q; piv_d = piv_q;
    rd_v_d = 1'b0; rd_j_d = j_q;
    prod_v_d = rd_v_q && (rd_j_q != i_q);
    dreq.go = 1'b0; dreq.num = acc_q; dreq.den = piv_q;
    // fold in each off-diagonal product; grab the diagonal as it passes
    if (prod_v_q) acc_d = acc_q - AW'(prod_q);
    if (rd_v_q && rd_j_q == i_q) piv_d = coef_rd_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && kind_i == jls_pkg::KIND_START) begin
          state_d = S_PIV; i_d = '0; j_d = '0; zp_d = 1'b0; conv_d = 1'b0;
          sw_d = '0;
        end
      end
      // read each diagonal (read data is registered, j_q marks when it arrives)
      S_PIV: begin
        if (j_q[0]) begin
          if (coef_rd_q == '0) zp_d = 1'b1;
          j_d = '0;
          if (i_q == n1) begin
            i_d = '0;
            if (zp_d) begin
              state_d = S_OUT;
            end else begin
              state_d = S_MAC; diff_d = 1'b0;
              acc_d = AW'($signed(rhs_q[0])) <<< 16;
            end
          end else begin
            i_d = i_q + IW'(1);
          end
        end else begin
          j_d = IW'(1);
        end
      end
      // one coefficient address per cycle across the row
      S_MAC: begin
        rd_v_d = 1'b1;
        if (j_q == n1) begin
          state_d = S_ADD;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      // drain the pipe, then hand the sum to the divider
      S_ADD: begin
        if (!rd_v_q && !prod_v_q) begin
          dreq.go = 1'b1; state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (chg_ge_tol(drsp.quo, cur_q[i_q])) diff_d = 1'b1;
          j_d = '0;
          if (i_q == n1) begin
            state_d = S_CHK;
          end else begin
            i_d = i_q + IW'(1); state_d = S_MAC;
            acc_d = AW'($signed(rhs_q[i_q + IW'(1)])) <<< 16;
          end
        end
      end
      S_CHK: begin
        sw_d = sw_q + 16'd1;
        i_d = '0;
        if (!diff_q) begin
          conv_d = 1'b1; state_d = S_OUT;
        end else begin
          state_d = S_COPY;
        end
      end
      S_COPY: begin
        if (sw_q == iters) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MAC; j_d = '0; diff_d = 1'b0;
          acc_d = AW'($signed(rhs_q[0])) <<< 16;
        end
      end
      S_OUT: begin
        i_d = i_q + IW'(1);
        if (i_q == n1) begin
          state_d = S_IDLE; i_d = '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; i_q <= '0; j_q <= '0; sw_q <= '0; zp_q <= 1'b0;
      conv_q <= 1'b0; diff_q <= 1'b0; rd_v_q <= 1'b0; prod_v_q <= 1'b0;
      rd_j_q <= '0;
    end else begin
      state_q <= state_d; i_q <= i_d; j_q <= j_d; sw_q <= sw_d; zp_q <= zp_d;
      conv_q <= conv_d; diff_q <= diff_d; rd_v_q <= rd_v_d; prod_v_q <= prod_v_d;
      rd_j_q <= rd_j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; piv_q <= piv_d;
  end

  // vector stores
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o && kind_i == jls_pkg::KIND_RHS) rhs_q[row_i] <= value_i;
    if (start_i && !busy_o && kind_i == jls_pkg::KIND_GUESS) cur_q[row_i] <= value_i;
    if (state_q == S_DIV && drsp.done) nxt_q[i_q] <= drsp.quo;
    if (state_q == S_COPY) begin
      for (int k = 0; k < jls_pkg::MaxSize; k++) begin
        if (IW'(k) <= n1) cur_q[k] <= nxt_q[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= (state_q == S_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    index_o <= i_q;
    solution_o <= (zp_q || !conv_q) ? cur_q[i_q] : nxt_q[i_q];
    converged_o <= conv_q;
    sweeps_used_o <= sw_q;
    zero_pivot_o <= zp_q;
    last_o <= (i_q == n1);
  end
endmodule

@@ design/jls_checker.sv @@
// Port-level checker for the Jacobi solver, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module jls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy_o,
  input logic       res_valid_o,
  input logic       last_o,
  input logic [3:0] index_o
);
  `CHK_IMPL(a_res_busy, clk_i, rst_ni, res_valid_o && !last_o, busy_o, "result outside solve")
  `CHK_NEXT(a_last_end, clk_i, rst_ni, res_valid_o && last_o, !res_valid_o, "run after last")
  `CHK_NEXT(a_idx_step, clk_i, rst_ni, res_valid_o && !last_o,
            res_valid_o && index_o == $past(index_o) + 4'd1, "index skipped")
endmodule

bind jacobi_linear_solver_unit jls_checker u_chk (
  .clk_i, .rst_ni, .busy_o, .res_valid_o, .last_o, .index_o
);
